FILE: sv/lcg_all_pole_shaped_noise_defines.svh
// Assertion macros for the shaped-noise source
`ifndef LCG_ALL_POLE_SHAPED_NOISE_DEFINES_SVH
`define LCG_ALL_POLE_SHAPED_NOISE_DEFINES_SVH

// same-cycle implication
`define LAPN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LAPN_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lapn_pkg.sv
// Types and constants shared by the shaped-noise source
`timescale 1ns / 1ps
package lapn_pkg;

  localparam int DATA_W  = 16;
  localparam int ACC_W   = 24;
  localparam int SEED_W  = 32;
  localparam int ORD_W   = 5;
  localparam int TAP_W   = 4;
  localparam int REQ_W   = 2;

  localparam logic [SEED_W-1:0] LCG_MUL      = 32'd1664525;
  localparam logic [SEED_W-1:0] LCG_ADD      = 32'd1013904223;
  localparam logic [SEED_W-1:0] SEED_RESET   = 32'd12345;
  localparam logic [DATA_W-1:0] NOISE_OFFSET = 16'd16384;
  localparam logic [ORD_W-1:0]  ORDER_RESET  = 5'd16;

  typedef enum logic [REQ_W-1:0] {
    REQ_GEN  = 2'd0,
    REQ_COEF = 2'd1,
    REQ_SEED = 2'd2,
    REQ_CLR  = 2'd3
  } req_t;

  typedef struct packed {
    logic init;
    logic mul_en;
    logic acc_en;
  } mac_ctl_t;

endpackage

FILE: sv/lapn_vram.sv
// Synchronous word memory with per-entry valid bits; unwritten entries read as zero
`timescale 1ns / 1ps
module lapn_vram import lapn_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DATA_W-1:0] rd_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r     <= mem[raddr];
    rd_vld_r <= vld_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  assign rdata = rd_vld_r ? rd_r : '0;

endmodule

FILE: sv/lapn_mac.sv
// Tap multiplier and feedback accumulator
`timescale 1ns / 1ps
module lapn_mac import lapn_pkg::*; (
  input  logic                     clk,
  input  mac_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] white,
  input  logic signed [DATA_W-1:0] coef,
  input  logic signed [DATA_W-1:0] hist,
  output logic signed [DATA_W-1:0] y
);

  logic signed [2*DATA_W-1:0] mul_r;
  logic        [ACC_W-1:0]    acc_r;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      mul_r <= coef * hist;
    end
    if (ctl.init) begin
      acc_r <= {white, 8'd0};
    end else if (ctl.acc_en) begin
      acc_r <= acc_r - mul_r[30:7];
    end
  end

  assign y = acc_r[23:8];

endmodule

FILE: sv/lcg_all_pole_shaped_noise.sv
// Top level: request decode, tap sequencer and output register of the shaped-noise source
// Generate word with active order n: the tap loop reads one coefficient and one history entry
// a cycle, the result is then registered, and the next word can be accepted in the cycle after;
// a stalled earlier result holds the finish. Coefficient, seed and clear words leave the source
// idle and give no result.
// Synchronous active-low reset: seed 12345, order 16, coefficients and history read as zero.
`timescale 1ns / 1ps
`include "lcg_all_pole_shaped_noise_defines.svh"
module lcg_all_pole_shaped_noise import lapn_pkg::*; #(
  parameter int MAX_ORDER = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [ORD_W-1:0]         cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic [TAP_W-1:0]         in_tap_index,
  input  logic signed [DATA_W-1:0] in_coeff_value,
  input  logic [SEED_W-1:0]        in_seed_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_noise_sample
);

  localparam int AW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CNT_W = $clog2(MAX_ORDER + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

  state_t               state_r, state_nxt;
  logic [ORD_W-1:0]     filter_order_r;
  logic [SEED_W-1:0]    seed_r;
  logic [CNT_W-1:0]     ord_r, iss_r, ord_clamp;
  logic [AW-1:0]        rd_idx_r;
  logic                 rd_vld_r, mul_vld_r, init_r;
  logic [DATA_W-1:0]    hold_r;
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_r;

  logic                 accept, issue, fin_go, wb;
  req_t                 req;
  logic                 coef_we, hist_we, hist_clr;
  logic [AW-1:0]        rd_addr, coef_waddr, hist_waddr;
  logic [DATA_W-1:0]    hist_wdata, coef_rdata, hist_rdata;
  logic signed [DATA_W-1:0] white, y;
  mac_ctl_t             ctl;

  assign req      = req_t'(in_req_type);
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign issue    = (state_r == ST_RUN) && (iss_r < ord_r);
  assign fin_go   = (state_r == ST_FIN) && !(out_valid_r && out_stall);
  assign wb       = rd_vld_r && (rd_idx_r != '0);
  assign rd_addr  = iss_r[AW-1:0];

  always_comb begin
    if (int'(filter_order_r) > MAX_ORDER) begin
      ord_clamp = CNT_W'(MAX_ORDER);
    end else begin
      ord_clamp = CNT_W'(filter_order_r);
    end
  end

  assign coef_we    = accept && (req == REQ_COEF) && (int'(in_tap_index) < MAX_ORDER);
  assign coef_waddr = AW'(in_tap_index);
  assign hist_clr   = accept && (req == REQ_CLR);
  assign hist_we    = fin_go || wb;
  assign hist_waddr = fin_go ? '0 : rd_idx_r;
  assign hist_wdata = fin_go ? y : hold_r;

  assign white = seed_r[31:16] - NOISE_OFFSET;

  assign ctl.init   = (state_r == ST_RUN) && init_r;
  assign ctl.mul_en = rd_vld_r;
  assign ctl.acc_en = mul_vld_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (req == REQ_GEN)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if ((iss_r == ord_r) && !rd_vld_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      filter_order_r <= ORDER_RESET;
      seed_r         <= SEED_RESET;
      iss_r          <= '0;
      ord_r          <= '0;
      rd_vld_r       <= 1'b0;
      mul_vld_r      <= 1'b0;
      init_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= issue;
      mul_vld_r <= rd_vld_r;
      if (cfg_wr_en) begin
        filter_order_r <= cfg_wr_data;
      end
      if (accept && (req == REQ_SEED)) begin
        seed_r <= in_seed_value;
      end else if (accept && (req == REQ_GEN)) begin
        seed_r <= SEED_W'(seed_r * LCG_MUL + LCG_ADD);
      end
      if (accept && (req == REQ_GEN)) begin
        iss_r  <= '0;
        ord_r  <= ord_clamp;
        init_r <= 1'b1;
      end else if (state_r == ST_RUN) begin
        init_r <= 1'b0;
        if (issue) begin
          iss_r <= iss_r + 1'b1;
        end
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx_r <= rd_addr;
    end
    if (rd_vld_r) begin
      hold_r <= hist_rdata;
    end
    if (fin_go) begin
      out_r <= y;
    end
  end

  lapn_vram #(.DEPTH(MAX_ORDER), .AW(AW)) u_coef_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (1'b0),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_coeff_value),
    .raddr (rd_addr),
    .rdata (coef_rdata)
  );

  lapn_vram #(.DEPTH(MAX_ORDER), .AW(AW)) u_hist_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (hist_clr),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (rd_addr),
    .rdata (hist_rdata)
  );

  lapn_mac u_mac (
    .clk   (clk),
    .ctl   (ctl),
    .white (white),
    .coef  (coef_rdata),
    .hist  (hist_rdata),
    .y     (y)
  );

  assign out_valid        = out_valid_r;
  assign out_noise_sample = out_r;

  `LAPN_ASSERT_NOW(a_idle_pipe_empty, !in_stall, !rd_vld_r && !mul_vld_r,
                   "tap pipeline busy while idle")
  `LAPN_ASSERT_NOW(a_iss_bound, state_r == ST_RUN, iss_r <= ord_r,
                   "tap counter beyond active order")
  `LAPN_ASSERT_NOW(a_no_rw_clash, hist_we && issue, hist_waddr != rd_addr,
                   "history write and read hit the same entry")
  `LAPN_ASSERT_NXT(a_fin_loads, fin_go, out_valid_r,
                   "finished word not presented")

endmodule

FILE: bench/lcg_all_pole_shaped_noise_tb.sv
// Self-checking testbench for the shaped-noise source: seed, coefficient and order sweep
`timescale 1ns / 1ps
module lcg_all_pole_shaped_noise_tb;
  import lapn_pkg::*;

  localparam int HIST_DEPTH  = 16;
  localparam int PHASE_WORDS = 175;
  localparam int SETTLE_CYC  = 32;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    req_t                     req;
    logic [TAP_W-1:0]         tap;
    logic signed [DATA_W-1:0] coeff;
    logic [SEED_W-1:0]        seed;
    int unsigned              gap;
    bit                       drain;
  } noise_word_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [ORD_W-1:0]         cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [REQ_W-1:0]         in_req_type = '0;
  logic [TAP_W-1:0]         in_tap_index = '0;
  logic signed [DATA_W-1:0] in_coeff_value = '0;
  logic [SEED_W-1:0]        in_seed_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_noise_sample;

  noise_word_t              pend_q[$];
  logic signed [DATA_W-1:0] sample_q[$];
  noise_word_t              cur_word;

  logic [SEED_W-1:0]        lcg_seed = SEED_RESET;
  logic signed [DATA_W-1:0] coef_mem[HIST_DEPTH];
  logic signed [DATA_W-1:0] hist_mem[HIST_DEPTH];
  logic [ORD_W-1:0]         active_order = ORDER_RESET;

  bit                       word_taken = 1'b0;
  bit                       gap_armed = 1'b0;
  int unsigned              gap_left = 0;
  int unsigned              stall_left = 0;
  int unsigned              in_idle_max = 5;
  int unsigned              out_idle_max = 5;
  int unsigned              quiet_cycles = 0;
  int unsigned              words_in = 0;
  int unsigned              samples_out = 0;
  int unsigned              order_writes = 0;
  int unsigned              err_cnt = 0;
  logic                     nxt_valid;
  logic signed [DATA_W-1:0] exp_sample;

  lcg_all_pole_shaped_noise u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_tap_index     (in_tap_index),
    .in_coeff_value   (in_coeff_value),
    .in_seed_value    (in_seed_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_noise_sample (out_noise_sample)
  );

  always #4 clk = ~clk;

  function automatic void shaped_noise_step(input noise_word_t w);
    longint                   acc;
    longint                   prod;
    longint                   scaled;
    logic signed [DATA_W-1:0] white;
    logic signed [DATA_W-1:0] y;
    int                       eff;
    case (w.req)
      REQ_COEF: begin
        coef_mem[w.tap] = w.coeff;
      end
      REQ_SEED: begin
        lcg_seed = w.seed;
      end
      REQ_CLR: begin
        for (int i = 0; i < HIST_DEPTH; i++) hist_mem[i] = '0;
      end
      default: begin
        eff = (active_order > HIST_DEPTH) ? HIST_DEPTH : int'(active_order);
        lcg_seed = lcg_seed * LCG_MUL + LCG_ADD;
        white = lcg_seed[31:16] - NOISE_OFFSET;
        acc = longint'(white) * 256;
        for (int i = 0; i < eff; i++) begin
          prod = longint'(coef_mem[i]) * longint'(hist_mem[i]);
          acc = acc - (prod >>> 7);
        end
        scaled = acc >>> 8;
        y = scaled[DATA_W-1:0];
        for (int i = eff - 1; i >= 1; i--) hist_mem[i] = hist_mem[i-1];
        hist_mem[0] = y;
        sample_q.push_back(y);
      end
    endcase
  endfunction

  function automatic void queue_word(input req_t req, input logic [TAP_W-1:0] tap,
                                     input logic signed [DATA_W-1:0] coeff,
                                     input logic [SEED_W-1:0] seed, input bit drain);
    noise_word_t w;
    w.req   = req;
    w.tap   = tap;
    w.coeff = coeff;
    w.seed  = seed;
    w.gap   = $urandom_range(0, in_idle_max);
    w.drain = drain;
    pend_q.push_back(w);
  endfunction

  function automatic void queue_random_word();
    int unsigned              pick;
    logic signed [DATA_W-1:0] c;
    req_t                     r;
    pick = $urandom_range(0, 99);
    if (pick < 70) r = REQ_GEN;
    else if (pick < 84) r = REQ_COEF;
    else if (pick < 92) r = REQ_SEED;
    else r = REQ_CLR;
    if ($urandom_range(0, 1) == 0) c = DATA_W'($urandom_range(0, 511)) - 16'sd256;
    else c = DATA_W'($urandom);
    queue_word(r, TAP_W'($urandom), c, $urandom, $urandom_range(0, 49) == 0);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (sample_q.size() == 0) begin
          $error("noise_sample: no sample expected, got %0d", out_noise_sample);
          err_cnt++;
        end else begin
          exp_sample = sample_q.pop_front();
          if (out_noise_sample !== exp_sample) begin
            $error("noise_sample: expected %0d, got %0d", exp_sample, out_noise_sample);
            err_cnt++;
          end
        end
        samples_out++;
        stall_left = $urandom_range(0, out_idle_max);
      end
      if (cfg_wr_en) active_order = cfg_wr_data;
      if (in_valid && !in_stall) begin
        shaped_noise_step(cur_word);
        word_taken = 1'b1;
        words_in++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  always @(negedge clk) begin
    nxt_valid = in_valid;
    if (word_taken) begin
      nxt_valid = 1'b0;
      word_taken = 1'b0;
    end
    if (!nxt_valid && rst_n && pend_q.size() > 0 &&
        !(pend_q[0].drain && sample_q.size() > 0)) begin
      if (!gap_armed) begin
        gap_left = pend_q[0].gap;
        gap_armed = 1'b1;
      end
      if (gap_left == 0) begin
        cur_word = pend_q.pop_front();
        gap_armed = 1'b0;
        nxt_valid = 1'b1;
        in_req_type    <= cur_word.req;
        in_tap_index   <= cur_word.tap;
        in_coeff_value <= cur_word.coeff;
        in_seed_value  <= cur_word.seed;
      end else begin
        gap_left--;
      end
    end
    in_valid <= nxt_valid;
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic drain_block();
    while (pend_q.size() > 0 || in_valid || sample_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_order(input logic [ORD_W-1:0] ord);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ord;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    order_writes++;
  endtask

  initial begin
    logic [ORD_W-1:0] orders[8];
    for (int i = 0; i < HIST_DEPTH; i++) begin
      coef_mem[i] = '0;
      hist_mem[i] = '0;
    end
    orders = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd17, 5'd0, 5'd0, 5'd0};
    for (int i = 5; i < 8; i++) orders[i] = ORD_W'($urandom_range(2, 15));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset state, seed extremes, coefficient extremes, clear
    queue_word(REQ_GEN,  4'd0,  16'sd0,       32'h0000_0000, 1'b0);
    queue_word(REQ_GEN,  4'd15, -16'sd1,      32'hFFFF_FFFF, 1'b0);
    queue_word(REQ_SEED, 4'd0,  16'sd0,       32'h0000_0000, 1'b0);
    queue_word(REQ_GEN,  4'd0,  16'sd0,       32'h0000_0000, 1'b0);
    queue_word(REQ_SEED, 4'd15, -16'sd1,      32'hFFFF_FFFF, 1'b0);
    queue_word(REQ_GEN,  4'd0,  16'sd0,       32'h0000_0000, 1'b0);
    queue_word(REQ_COEF, 4'd0,  -16'sd32768,  32'h0000_0000, 1'b0);
    queue_word(REQ_COEF, 4'd15, 16'sd32767,   32'hFFFF_FFFF, 1'b0);
    queue_word(REQ_COEF, 4'd5,  16'sh5555,    32'h5555_5555, 1'b0);
    queue_word(REQ_COEF, 4'd10, 16'shAAAA,    32'hAAAA_AAAA, 1'b0);
    queue_word(REQ_COEF, 4'd1,  16'sd64,      32'h0000_0000, 1'b0);
    for (int i = 0; i < 6; i++) queue_word(REQ_GEN, 4'd0, 16'sd0, 32'h0, 1'b0);
    queue_word(REQ_CLR,  4'd0,  16'sd0,       32'h0000_0000, 1'b1);
    queue_word(REQ_GEN,  4'd0,  16'sd0,       32'h0000_0000, 1'b0);
    queue_word(REQ_GEN,  4'd0,  16'sd0,       32'h0000_0000, 1'b0);
    queue_word(REQ_SEED, 4'd0,  16'sd0,       32'd12345,     1'b0);
    queue_word(REQ_GEN,  4'd0,  16'sd0,       32'h0000_0000, 1'b0);
    drain_block();

    foreach (orders[p]) begin
      if (p % 3 == 2) begin
        in_idle_max  = 0;
        out_idle_max = 0;
      end else begin
        in_idle_max  = 5;
        out_idle_max = 5;
      end
      write_order(orders[p]);
      for (int i = 0; i < PHASE_WORDS; i++) queue_random_word();
      drain_block();
    end

    if (sample_q.size() > 0) begin
      $error("noise_sample: %0d expected samples never arrived", sample_q.size());
      err_cnt++;
    end
    $display("Accepted %0d words and checked %0d noise samples", words_in, samples_out);
    $display("Swept %0d filter orders including 0, 1, 16, 17 and 31", order_writes);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/lapn_pkg.sv
sv/lapn_vram.sv
sv/lapn_mac.sv
sv/lcg_all_pole_shaped_noise.sv
bench/lcg_all_pole_shaped_noise_tb.sv
